### rtl/rpn_pkg.sv
`default_nettype none
package rpn_pkg;
  localparam int unsigned StackDepth = 64;
  localparam int unsigned PtrW = $clog2(StackDepth);
  localparam int unsigned CntW = $clog2(StackDepth + 1);

  typedef enum logic [2:0] {
    CMD_PUSH = 3'd0,
    CMD_ADD  = 3'd1,
    CMD_SUB  = 3'd2,
    CMD_MUL  = 3'd3,
    CMD_DIV  = 3'd4,
    CMD_POW  = 3'd5,
    CMD_END  = 3'd6,
    CMD_NOP  = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DIVZERO   = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_NORESULT  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_RDR, S_RDL, S_EXEC, S_ITER, S_FIX, S_WRITE, S_RDTOP, S_TOPW, S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       load_in;
    logic       rd_right;
    logic       rd_left;
    logic       rd_top;
    logic       cap_right;
    logic       cap_left;
    logic       cap_top;
    logic       start_op;
    logic       iter;
    logic       fix;
    logic       wr_push;
    logic       wr_res;
    logic       set_err;
    logic [2:0] err_code;
    logic       do_end;
    logic       load_out;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0]      cmd;
    logic [CntW-1:0] sp;
    logic            err_set;
    logic            rhs_zero;
    logic            iter_last;
  } stat_t;
endpackage
`default_nettype wire

### rtl/rpn_stack_calculator_unit.sv
`default_nettype none
// RPN stack calculator: takes one token per input transaction (in_cmd,
// in_operand_value) on a valid/ready channel and returns one result
// transaction per token (top, entry count, status, answer flag, end flag).
// Tokens are processed one at a time. Divide and power run the 32-step
// shift-subtract divider and the 32-step square-and-multiply loop, which
// share the operand registers. The next token is accepted in the cycle
// after the result is loaded. The stack sits in a 64-entry single-port
// memory with registered read, so each operand read passes through the
// read data register.
// Reset clears the stack pointer, the error code and the output valid; the
// stack memory itself is not cleared and needs no sweep.
// A finished result is held in the output register while out_ready is low;
// the next token is accepted once that result has been loaded, so a stalled
// receiver holds the whole block after at most one pending token.
module rpn_stack_calculator_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_cmd,
  input  wire logic signed [31:0] in_operand_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_top_value,
  output logic [6:0]              out_entry_count,
  output logic [2:0]              out_status,
  output logic                    out_answer_valid,
  output logic                    out_expr_done
);
  rpn_pkg::ctrl_t ctrl;
  rpn_pkg::stat_t stat;

  rpn_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .stat, .ctrl
  );

  rpn_datapath u_dp (
    .clk, .rst_n, .ctrl, .stat, .in_cmd, .in_operand_value, .out_top_value,
    .out_entry_count, .out_status, .out_answer_valid, .out_expr_done
  );

  // stack never exceeds its depth
  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    stat.sp <= rpn_pkg::CntW'(rpn_pkg::StackDepth)) else $error("stack pointer out of range");
  // answer flag only on an end result
  a_ans_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_answer_valid |-> out_expr_done) else $error("answer without end");
  // end result always reports an empty stack
  a_end_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_expr_done |-> out_entry_count == 7'd0) else $error("end count");
  // no new token while a result is pending in the pipeline
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second token accepted");
endmodule
`default_nettype wire

### rtl/rpn_datapath.sv
`default_nettype none
module rpn_datapath (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire rpn_pkg::ctrl_t            ctrl,
  output rpn_pkg::stat_t                 stat,
  input  wire logic [2:0]                in_cmd,
  input  wire logic signed [31:0]        in_operand_value,
  output logic signed [31:0]             out_top_value,
  output logic [6:0]                     out_entry_count,
  output logic [2:0]                     out_status,
  output logic                           out_answer_valid,
  output logic                           out_expr_done
);
  logic [31:0] mem [rpn_pkg::StackDepth];
  logic [31:0] rd_data_r;
  logic [rpn_pkg::PtrW-1:0] rd_addr;
  logic [2:0]  cmd_r;
  logic [31:0] val_r, rhs_r, lhs_r, top_r;
  logic [rpn_pkg::CntW-1:0] sp_r, sp_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [31:0] acc_r, base_r, rem_r, quo_r, exp_r;
  logic [5:0]  cnt_r;
  logic [31:0] res;
  logic [31:0] l_mag, r_mag;
  logic [32:0] trial;
  logic [31:0] mul_ab, sq;

  assign l_mag = lhs_r[31] ? (32'd0 - lhs_r) : lhs_r;
  assign r_mag = rhs_r[31] ? (32'd0 - rhs_r) : rhs_r;

  // read address selection
  always_comb begin
    rd_addr = rpn_pkg::PtrW'(sp_r - 1'b1);
    if (ctrl.rd_left) rd_addr = rpn_pkg::PtrW'(sp_r - 2'd2);
  end

  // stack memory with registered read
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    if (ctrl.wr_push) mem[rpn_pkg::PtrW'(sp_r)] <= val_r;
    if (ctrl.wr_res)  mem[rpn_pkg::PtrW'(sp_r - 2'd2)] <= res;
  end

  // one step of the power loop (square, conditional multiply) and the divider trial subtract
  assign mul_ab = acc_r * base_r;
  assign sq     = base_r * base_r;
  assign trial  = {rem_r, quo_r[31]} - {1'b0, r_mag};

  always_comb begin
    case (cmd_r)
      rpn_pkg::CMD_ADD: res = lhs_r + rhs_r;
      rpn_pkg::CMD_SUB: res = lhs_r - rhs_r;
      rpn_pkg::CMD_MUL: res = acc_r;
      rpn_pkg::CMD_DIV: res = acc_r;
      rpn_pkg::CMD_POW: res = acc_r;
      default:          res = lhs_r;
    endcase
  end

  // operand capture and iterative units
  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      cmd_r <= in_cmd;
      val_r <= in_operand_value;
    end
    if (ctrl.cap_right) rhs_r <= rd_data_r;
    if (ctrl.cap_left)  lhs_r <= rd_data_r;
    if (ctrl.cap_top)   top_r <= rd_data_r;
    if (ctrl.start_op) begin
      cnt_r  <= 6'd0;
      rem_r  <= 32'd0;
      quo_r  <= l_mag;
      base_r <= lhs_r;
      exp_r  <= rhs_r;
      acc_r  <= (cmd_r == rpn_pkg::CMD_MUL) ? (lhs_r * rhs_r) : 32'd1;
    end else if (ctrl.iter) begin
      cnt_r <= cnt_r + 6'd1;
      if (cmd_r == rpn_pkg::CMD_DIV) begin
        if (!trial[32]) begin
          rem_r <= trial[31:0];
          quo_r <= {quo_r[30:0], 1'b1};
        end else begin
          rem_r <= {rem_r[30:0], quo_r[31]};
          quo_r <= {quo_r[30:0], 1'b0};
        end
      end else begin
        if (exp_r[0]) acc_r <= mul_ab;
        base_r <= sq;
        exp_r  <= {1'b0, exp_r[31:1]};
      end
    end else if (ctrl.fix) begin
      if (cmd_r == rpn_pkg::CMD_DIV)
        acc_r <= (lhs_r[31] ^ rhs_r[31]) ? (32'd0 - quo_r) : quo_r;
      else if (rhs_r[31])
        acc_r <= 32'd0;
    end
  end

  // stack pointer and sticky error
  always_comb begin
    sp_nxt  = sp_r;
    err_nxt = err_r;
    if (ctrl.wr_push) sp_nxt = sp_r + 1'b1;
    if (ctrl.wr_res)  sp_nxt = sp_r - 1'b1;
    if (ctrl.set_err) err_nxt = ctrl.err_code;
    if (ctrl.do_end) begin
      sp_nxt  = '0;
      err_nxt = rpn_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r  <= '0;
      err_r <= rpn_pkg::ST_OK;
    end else begin
      sp_r  <= sp_nxt;
      err_r <= err_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      out_expr_done    <= ctrl.do_end;
      out_entry_count  <= ctrl.do_end ? 7'd0 : 7'(sp_nxt);
      if (ctrl.do_end) begin
        out_answer_valid <= (err_r == rpn_pkg::ST_OK) && (sp_r != '0);
        out_status <= (err_r != rpn_pkg::ST_OK) ? err_r :
                      (sp_r == '0) ? rpn_pkg::ST_NORESULT : rpn_pkg::ST_OK;
        out_top_value <= ((err_r == rpn_pkg::ST_OK) && (sp_r != '0)) ? top_r : 32'd0;
      end else begin
        out_answer_valid <= 1'b0;
        out_status       <= err_nxt;
        out_top_value    <= (sp_nxt == '0) ? 32'd0 : top_r;
      end
    end
  end

  assign stat.cmd       = cmd_r;
  assign stat.sp        = sp_r;
  assign stat.err_set   = (err_r != rpn_pkg::ST_OK);
  assign stat.rhs_zero  = (rhs_r == 32'd0);
  assign stat.iter_last = (cnt_r == 6'd31);
endmodule
`default_nettype wire

### rtl/rpn_ctrl.sv
`default_nettype none
module rpn_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire rpn_pkg::stat_t stat,
  output rpn_pkg::ctrl_t      ctrl
);
  rpn_pkg::state_t state_r, state_nxt;
  logic ov_r, ov_nxt;
  logic out_free;

  assign out_free = !ov_r || out_ready;
  assign in_ready = (state_r == rpn_pkg::S_IDLE);
  assign out_valid = ov_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rpn_pkg::S_IDLE:   if (in_valid) state_nxt = rpn_pkg::S_DECODE;
      rpn_pkg::S_DECODE: begin
        if (stat.cmd == rpn_pkg::CMD_END) state_nxt = (stat.sp != '0) ? rpn_pkg::S_TOPW
                                                                    : rpn_pkg::S_OUT;
        else if (stat.err_set || stat.cmd == rpn_pkg::CMD_NOP) state_nxt = rpn_pkg::S_RDTOP;
        else if (stat.cmd == rpn_pkg::CMD_PUSH) begin
          if (stat.sp >= rpn_pkg::CntW'(rpn_pkg::StackDepth)) state_nxt = rpn_pkg::S_RDTOP;
          else state_nxt = rpn_pkg::S_WRITE;
        end else if (stat.sp < rpn_pkg::CntW'(2)) state_nxt = rpn_pkg::S_RDTOP;
        else state_nxt = rpn_pkg::S_RDR;
      end
      rpn_pkg::S_RDR:   state_nxt = rpn_pkg::S_RDL;
      rpn_pkg::S_RDL:   state_nxt = rpn_pkg::S_EXEC;
      rpn_pkg::S_EXEC: begin
        if (stat.cmd == rpn_pkg::CMD_DIV && stat.rhs_zero) state_nxt = rpn_pkg::S_RDTOP;
        else if (stat.cmd == rpn_pkg::CMD_ADD || stat.cmd == rpn_pkg::CMD_SUB ||
                 stat.cmd == rpn_pkg::CMD_MUL) state_nxt = rpn_pkg::S_WRITE;
        else state_nxt = rpn_pkg::S_ITER;
      end
      rpn_pkg::S_ITER:  if (stat.iter_last) state_nxt = rpn_pkg::S_FIX;
      rpn_pkg::S_FIX:   state_nxt = rpn_pkg::S_WRITE;
      rpn_pkg::S_WRITE: state_nxt = rpn_pkg::S_RDTOP;
      rpn_pkg::S_RDTOP: state_nxt = rpn_pkg::S_TOPW;
      rpn_pkg::S_TOPW:  state_nxt = rpn_pkg::S_OUT;
      rpn_pkg::S_OUT:   if (out_free) state_nxt = rpn_pkg::S_IDLE;
      default:          state_nxt = rpn_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl = '0;
    ctrl.err_code = rpn_pkg::ST_OK;
    case (state_r)
      rpn_pkg::S_IDLE: ctrl.load_in = in_valid;
      rpn_pkg::S_DECODE: begin
        ctrl.rd_top = 1'b1;
        if (stat.cmd != rpn_pkg::CMD_END && !stat.err_set &&
            stat.cmd != rpn_pkg::CMD_NOP) begin
          if (stat.cmd == rpn_pkg::CMD_PUSH) begin
            if (stat.sp >= rpn_pkg::CntW'(rpn_pkg::StackDepth)) begin
              ctrl.set_err  = 1'b1;
              ctrl.err_code = rpn_pkg::ST_OVERFLOW;
            end
          end else if (stat.sp < rpn_pkg::CntW'(2)) begin
            ctrl.set_err  = 1'b1;
            ctrl.err_code = rpn_pkg::ST_UNDERFLOW;
          end
        end
      end
      rpn_pkg::S_RDR: begin
        ctrl.cap_right = 1'b1;
        ctrl.rd_left   = 1'b1;
      end
      rpn_pkg::S_RDL: ctrl.cap_left = 1'b1;
      rpn_pkg::S_EXEC: begin
        ctrl.start_op = 1'b1;
        if (stat.cmd == rpn_pkg::CMD_DIV && stat.rhs_zero) begin
          ctrl.set_err  = 1'b1;
          ctrl.err_code = rpn_pkg::ST_DIVZERO;
        end
      end
      rpn_pkg::S_ITER: ctrl.iter = 1'b1;
      rpn_pkg::S_FIX:  ctrl.fix = 1'b1;
      rpn_pkg::S_WRITE: begin
        if (stat.cmd == rpn_pkg::CMD_PUSH) ctrl.wr_push = 1'b1;
        else ctrl.wr_res = 1'b1;
      end
      rpn_pkg::S_RDTOP: ctrl.rd_top = 1'b1;
      rpn_pkg::S_TOPW:  ctrl.cap_top = 1'b1;
      rpn_pkg::S_OUT: begin
        ctrl.load_out = out_free;
        ctrl.do_end   = out_free && (stat.cmd == rpn_pkg::CMD_END);
      end
      default: ;
    endcase
  end

  // hold the result until taken
  always_comb begin
    ov_nxt = ov_r;
    if (out_ready) ov_nxt = 1'b0;
    if (ctrl.load_out) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rpn_pkg::S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end
endmodule
`default_nettype wire
